FILE: rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants for the bracket balance checker: bracket codes,
// stack cell operations and verdict causes.
// ----------------------------------------------------------------------------
package bbc_pkg;

    typedef enum logic [1:0] {
        BR_ROUND  = 2'd0,
        BR_CURLY  = 2'd1,
        BR_SQUARE = 2'd2
    } t_bracket;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } t_stack_op;

    typedef struct packed {
        logic     is_open;
        logic     is_close;
        t_bracket kind;
    } t_bracket_info;

    localparam logic [1:0] CAUSE_END_EMPTY = 2'd0;
    localparam logic [1:0] CAUSE_NO_VERDICT = 2'd1;
    localparam logic [1:0] CAUSE_OVERFLOW  = 2'd2;

    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5b;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5d;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7b;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7d;

    function automatic t_bracket_info decode_bracket(input logic [7:0] ch);
        t_bracket_info info;
        info = '{is_open: 1'b0, is_close: 1'b0, kind: BR_ROUND};
        unique case (ch)
            CH_OPEN_ROUND:   info = '{is_open: 1'b1, is_close: 1'b0, kind: BR_ROUND};
            CH_OPEN_CURLY:   info = '{is_open: 1'b1, is_close: 1'b0, kind: BR_CURLY};
            CH_OPEN_SQUARE:  info = '{is_open: 1'b1, is_close: 1'b0, kind: BR_SQUARE};
            CH_CLOSE_ROUND:  info = '{is_open: 1'b0, is_close: 1'b1, kind: BR_ROUND};
            CH_CLOSE_CURLY:  info = '{is_open: 1'b0, is_close: 1'b1, kind: BR_CURLY};
            CH_CLOSE_SQUARE: info = '{is_open: 1'b0, is_close: 1'b1, kind: BR_SQUARE};
            default:         info = '{is_open: 1'b0, is_close: 1'b0, kind: BR_ROUND};
        endcase
        return info;
    endfunction

endpackage

FILE: rtl/bbc_cell.sv
// ----------------------------------------------------------------------------
// bbc_cell
// One entry of the shifting bracket stack. On a push it takes the entry of the
// cell above, on a pop the entry of the cell below, otherwise it holds.
// ----------------------------------------------------------------------------
module bbc_cell import bbc_pkg::*; (
    input  logic      i_clk,
    input  t_stack_op i_op,
    input  t_bracket  i_from_above,
    input  t_bracket  i_from_below,
    output t_bracket  o_value
);

    t_bracket r_value;
    t_bracket n_value;

    always_comb begin
        unique case (i_op)
            OP_PUSH: n_value = i_from_above;
            OP_POP:  n_value = i_from_below;
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

FILE: rtl/bracket_balance_checker_top.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker_top
// Streams source text one byte per item, tracks begin/end keywords and a
// stack of open brackets, and reports a balance verdict per text.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle while o_stall is low, and its result, if
// any, sits in the output register in the next cycle. The rate is set by the
// combinational word match and the stack top, which always lives in the first
// cell of a row of STACK_DEPTH shifting cells, so a push or pop never waits on
// a memory port. A new item is taken while a result waits, as long as the
// output register is free or being emptied in the same cycle. The stack needs
// no clearing after reset or the last byte; only its entry count is cleared.
// ----------------------------------------------------------------------------
module bracket_balance_checker_top import bbc_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_balanced,
    output logic [1:0] o_verdict_cause
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    typedef enum logic [9:0] {
        W_EMPTY = 10'b0000000001,
        W_B     = 10'b0000000010,
        W_BE    = 10'b0000000100,
        W_BEG   = 10'b0000001000,
        W_BEGI  = 10'b0000010000,
        W_BEGIN = 10'b0000100000,
        W_E     = 10'b0001000000,
        W_EN    = 10'b0010000000,
        W_END   = 10'b0100000000,
        W_OTHER = 10'b1000000000
    } t_word;

    t_word         r_word, n_word, w_word;
    logic [CW-1:0] r_count, n_count;
    logic          r_begin_seen, n_begin_seen;
    logic          r_verdict_given, n_verdict_given;
    logic          r_out_valid, n_out_valid;
    logic          r_balanced, n_balanced;
    logic [1:0]    r_cause, n_cause;

    logic          w_accept;
    logic          w_letter;
    logic          w_load;
    t_bracket_info w_br;
    t_stack_op     w_op;
    t_bracket      w_cell [STACK_DEPTH];

    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;
    assign w_br     = decode_bracket(i_char_code);
    assign w_letter = (i_char_code >= 8'h61 && i_char_code <= 8'h7a) ||
                      (i_char_code >= 8'h41 && i_char_code <= 8'h5a);

    // word run
    always_comb begin
        w_word = W_OTHER;
        if (!w_letter) begin
            w_word = W_EMPTY;
        end else begin
            unique case (r_word)
                W_EMPTY: w_word = (i_char_code == 8'h62) ? W_B :
                                  (i_char_code == 8'h65) ? W_E : W_OTHER;
                W_B:     w_word = (i_char_code == 8'h65) ? W_BE : W_OTHER;
                W_BE:    w_word = (i_char_code == 8'h67) ? W_BEG : W_OTHER;
                W_BEG:   w_word = (i_char_code == 8'h69) ? W_BEGI : W_OTHER;
                W_BEGI:  w_word = (i_char_code == 8'h6e) ? W_BEGIN : W_OTHER;
                W_E:     w_word = (i_char_code == 8'h6e) ? W_EN : W_OTHER;
                W_EN:    w_word = (i_char_code == 8'h64) ? W_END : W_OTHER;
                default: w_word = W_OTHER;
            endcase
        end
    end

    always_comb begin
        n_word          = r_word;
        n_count         = r_count;
        n_begin_seen    = r_begin_seen;
        n_verdict_given = r_verdict_given;
        n_balanced      = r_balanced;
        n_cause         = r_cause;
        w_op            = OP_HOLD;
        w_load          = 1'b0;
        if (w_accept && !r_verdict_given) begin
            n_word = w_word;
            if (w_word == W_BEGIN) begin
                n_begin_seen = 1'b1;
            end
            if (w_word == W_END && r_count == '0 && r_begin_seen) begin
                w_load          = 1'b1;
                n_balanced      = 1'b1;
                n_cause         = CAUSE_END_EMPTY;
                n_verdict_given = 1'b1;
            end else if (w_br.is_open) begin
                if (r_count < DEPTH_C) begin
                    w_op    = OP_PUSH;
                    n_count = r_count + CW'(1);
                end else begin
                    w_load          = 1'b1;
                    n_balanced      = 1'b0;
                    n_cause         = CAUSE_OVERFLOW;
                    n_verdict_given = 1'b1;
                end
            end else if (w_br.is_close && r_count != '0 && w_cell[0] == w_br.kind) begin
                w_op    = OP_POP;
                n_count = r_count - CW'(1);
            end
            if (i_last_byte && !w_load) begin
                w_load     = 1'b1;
                n_balanced = 1'b0;
                n_cause    = CAUSE_NO_VERDICT;
            end
        end
        if (w_accept && i_last_byte) begin
            n_word          = W_EMPTY;
            n_count         = '0;
            n_begin_seen    = 1'b0;
            n_verdict_given = 1'b0;
        end
        n_out_valid = w_load | (r_out_valid & i_stall);
    end

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            t_bracket w_above;
            t_bracket w_below;
            if (gi == 0) begin : g_top
                assign w_above = w_br.kind;
            end else begin : g_mid
                assign w_above = w_cell[gi-1];
            end
            if (gi == STACK_DEPTH - 1) begin : g_bottom
                assign w_below = w_cell[gi];
            end else begin : g_rest
                assign w_below = w_cell[gi+1];
            end
            bbc_cell u_cell (
                .i_clk        (i_clk),
                .i_op         (w_op),
                .i_from_above (w_above),
                .i_from_below (w_below),
                .o_value      (w_cell[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word          <= W_EMPTY;
            r_count         <= '0;
            r_begin_seen    <= 1'b0;
            r_verdict_given <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_word          <= n_word;
            r_count         <= n_count;
            r_begin_seen    <= n_begin_seen;
            r_verdict_given <= n_verdict_given;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_balanced <= n_balanced;
        r_cause    <= n_cause;
    end

    assign o_valid         = r_out_valid;
    assign o_balanced      = r_balanced;
    assign o_verdict_cause = r_cause;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("stack count beyond depth");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last_byte) |=> (r_count == '0 && !r_verdict_given && !r_begin_seen))
        else $error("state not cleared after last item");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == OP_POP) |-> (r_count != '0))
        else $error("pop on empty stack");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && n_cause == CAUSE_OVERFLOW) |-> (r_count == DEPTH_C))
        else $error("overflow verdict with stack not full");

    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_verdict_cause) && $stable(o_balanced)))
        else $error("stalled result lost or changed");

endmodule
